// File: rtl/lup_pkg.sv
// lup_pkg: shared widths, codes, command and status structs for the lup solver
// used by lup_div, lup_dp, lup_ctrl and lup_linear_system_solver
`timescale 1ns / 1ps

package lup_pkg;

  localparam int MAX_ORDER = 16;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MAT_DEPTH = 1 << ADDR_W;
  localparam int N_LIMIT   = (MAX_ORDER < 16) ? MAX_ORDER : 16;
  localparam int PROD_W    = 2 * DATA_W - FRAC_BITS;
  localparam int ACC_W     = PROD_W + IDX_W + 2;
  localparam int DVD_W     = DATA_W + FRAC_BITS;
  localparam int CNT_W     = $clog2(DVD_W + 1);
  localparam int SIZE_W    = 5;
  localparam int MINP_W    = 17;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;

  localparam logic [1:0] ACT_WRITE_A = 2'd0;
  localparam logic [1:0] ACT_WRITE_B = 2'd1;
  localparam logic [1:0] ACT_SOLVE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PIVOT = CFG_IDX_W'(1);

  localparam logic signed [ACC_W-1:0] ACC_MAX =
    {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN =
    {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    SRC_IN   = 3'd0,
    SRC_TMP  = 3'd1,
    SRC_MEMQ = 3'd2,
    SRC_RHS  = 3'd3,
    SRC_SAT  = 3'd4,
    SRC_DIV  = 3'd5
  } src_t;

  typedef enum logic [1:0] {
    ACC_HOLD      = 2'd0,
    ACC_LOAD_VEC  = 2'd1,
    ACC_LOAD_DIFF = 2'd2,
    ACC_SUB       = 2'd3
  } acc_op_t;

  typedef enum logic {
    MUL_M = 1'b0,
    MUL_V = 1'b1
  } mul_sel_t;

  typedef enum logic {
    DIV_MAT = 1'b0,
    DIV_ACC = 1'b1
  } div_src_t;

  typedef struct packed {
    logic [ADDR_W-1:0] mat_raddr;
    logic              mat_we;
    logic [ADDR_W-1:0] mat_waddr;
    src_t              mat_src;
    logic [IDX_W-1:0]  vec_raddr;
    logic              vec_we;
    logic [IDX_W-1:0]  vec_waddr;
    src_t              vec_src;
    logic [IDX_W-1:0]  rhs_raddr;
    logic              rhs_we;
    logic [IDX_W-1:0]  rhs_waddr;
    logic              tmp_ld;
    logic              best_init;
    logic              best_cmp;
    logic              prod_ld;
    mul_sel_t          mul_sel;
    acc_op_t           acc_op;
    logic              div_start;
    div_src_t          div_src;
    logic              m_ld;
    logic              ovf_clr;
    logic              out_ld;
    logic              out_sing;
    logic [IDX_W-1:0]  out_index;
    logic              out_last;
    logic [MINP_W-1:0] min_pivot;
  } cmd_t;

  typedef struct packed {
    logic gt;
    logic low;
    logic div_busy;
    logic div_done;
  } status_t;

  function automatic logic sat_hit(input logic signed [ACC_W-1:0] v);
    return (v > ACC_MAX) || (v < ACC_MIN);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_val(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > ACC_MAX) begin
      r = ACC_MAX[DATA_W-1:0];
    end else if (v < ACC_MIN) begin
      r = ACC_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/lup_div.sv
// lup_div: radix-2 restoring divider for (a << FRAC_BITS) / b, truncated, saturated
// depends on lup_pkg
`timescale 1ns / 1ps

module lup_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [lup_pkg::DATA_W-1:0] dividend,
  input  logic signed [lup_pkg::DATA_W-1:0] divisor,
  output logic                              busy,
  output logic                              done,
  output logic signed [lup_pkg::DATA_W-1:0] quot,
  output logic                              ovf
);

  logic                        run;
  logic                        fin;
  logic [lup_pkg::CNT_W-1:0]   cnt;
  logic [lup_pkg::DVD_W-1:0]   num;
  logic [lup_pkg::DATA_W-1:0]  den;
  logic [lup_pkg::DATA_W-1:0]  rem;
  logic                        neg;
  logic [lup_pkg::DATA_W:0]    trial;
  logic                        qbit;
  logic [lup_pkg::DATA_W-1:0]  mag_a;
  logic [lup_pkg::DATA_W-1:0]  mag_b;
  logic                        pos_over;
  logic                        neg_over;

  assign mag_a = dividend[lup_pkg::DATA_W-1] ? -dividend : dividend;
  assign mag_b = divisor[lup_pkg::DATA_W-1] ? -divisor : divisor;
  assign trial = {rem, num[lup_pkg::DVD_W-1]};
  assign qbit  = trial >= {1'b0, den};

  assign pos_over = num[lup_pkg::DVD_W-1:lup_pkg::DATA_W-1] != '0;
  assign neg_over = (num[lup_pkg::DVD_W-1:lup_pkg::DATA_W] != '0) ||
                    (num[lup_pkg::DATA_W-1] && (num[lup_pkg::DATA_W-2:0] != '0));

  assign busy = run | fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= lup_pkg::CNT_W'(lup_pkg::DVD_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == lup_pkg::CNT_W'(1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= {mag_a, {lup_pkg::FRAC_BITS{1'b0}}};
      den <= mag_b;
      rem <= '0;
      neg <= dividend[lup_pkg::DATA_W-1] ^ divisor[lup_pkg::DATA_W-1];
    end else if (run) begin
      // quotient bits shift in where dividend bits leave
      rem <= qbit ? lup_pkg::DATA_W'(trial - {1'b0, den}) : trial[lup_pkg::DATA_W-1:0];
      num <= {num[lup_pkg::DVD_W-2:0], qbit};
    end else if (fin) begin
      if (!neg) begin
        ovf  <= pos_over;
        quot <= pos_over ? {1'b0, {(lup_pkg::DATA_W-1){1'b1}}} : num[lup_pkg::DATA_W-1:0];
      end else begin
        ovf  <= neg_over;
        quot <= neg_over ? {1'b1, {(lup_pkg::DATA_W-1){1'b0}}}
                         : -num[lup_pkg::DATA_W-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst) done |-> $past(fin))
    else $error("divider done without final step");
`endif

endmodule

// File: rtl/lup_dp.sv
// lup_dp: datapath with matrix, rhs and work memories, multiplier, accumulator, divider
// depends on lup_pkg and lup_div
`timescale 1ns / 1ps

module lup_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  lup_pkg::cmd_t                     cmd,
  input  logic signed [lup_pkg::DATA_W-1:0] value,
  output lup_pkg::status_t                  st,
  output logic [lup_pkg::IDX_W-1:0]         out_index,
  output logic signed [lup_pkg::DATA_W-1:0] out_sol,
  output logic                              out_status,
  output logic                              out_ovf,
  output logic                              out_last
);

  logic signed [lup_pkg::DATA_W-1:0] mat [lup_pkg::MAT_DEPTH];
  logic signed [lup_pkg::DATA_W-1:0] vec [lup_pkg::MAX_ORDER];
  logic signed [lup_pkg::DATA_W-1:0] rhs [lup_pkg::MAX_ORDER];

  logic signed [lup_pkg::DATA_W-1:0]   mat_q;
  logic signed [lup_pkg::DATA_W-1:0]   vec_q;
  logic signed [lup_pkg::DATA_W-1:0]   rhs_q;
  logic signed [lup_pkg::DATA_W-1:0]   tmp;
  logic signed [lup_pkg::DATA_W-1:0]   vtmp;
  logic signed [lup_pkg::DATA_W-1:0]   m;
  logic [lup_pkg::DATA_W-1:0]          best;
  logic signed [lup_pkg::PROD_W-1:0]   prod;
  logic signed [lup_pkg::ACC_W-1:0]    acc;
  logic                                ovf;

  logic signed [2*lup_pkg::DATA_W-1:0] full;
  logic signed [lup_pkg::DATA_W-1:0]   mul_b;
  logic [lup_pkg::DATA_W-1:0]          mag_q;
  logic signed [lup_pkg::DATA_W-1:0]   acc_sat;
  logic                                acc_ovf;
  logic signed [lup_pkg::DATA_W-1:0]   div_a;
  logic signed [lup_pkg::DATA_W-1:0]   div_q;
  logic                                div_ovf;
  logic                                div_busy;
  logic                                div_done;
  logic signed [lup_pkg::DATA_W-1:0]   mat_wdata;
  logic signed [lup_pkg::DATA_W-1:0]   vec_wdata;

  assign mul_b   = (cmd.mul_sel == lup_pkg::MUL_M) ? m : vec_q;
  assign full    = mat_q * mul_b;
  assign mag_q   = mat_q[lup_pkg::DATA_W-1] ? -mat_q : mat_q;
  assign acc_sat = lup_pkg::sat_val(acc);
  assign acc_ovf = lup_pkg::sat_hit(acc);
  assign div_a   = (cmd.div_src == lup_pkg::DIV_MAT) ? mat_q : acc_sat;

  assign st.gt       = mag_q > best;
  assign st.low      = (best == '0) ||
                       (best < {{(lup_pkg::DATA_W-lup_pkg::MINP_W){1'b0}}, cmd.min_pivot});
  assign st.div_busy = div_busy;
  assign st.div_done = div_done;

  lup_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (tmp),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q),
    .ovf      (div_ovf)
  );

  always_comb begin
    unique case (cmd.mat_src)
      lup_pkg::SRC_TMP:  mat_wdata = tmp;
      lup_pkg::SRC_MEMQ: mat_wdata = mat_q;
      lup_pkg::SRC_SAT:  mat_wdata = acc_sat;
      lup_pkg::SRC_DIV:  mat_wdata = div_q;
      default:           mat_wdata = value;
    endcase
    unique case (cmd.vec_src)
      lup_pkg::SRC_TMP:  vec_wdata = vtmp;
      lup_pkg::SRC_MEMQ: vec_wdata = vec_q;
      lup_pkg::SRC_RHS:  vec_wdata = rhs_q;
      lup_pkg::SRC_SAT:  vec_wdata = acc_sat;
      lup_pkg::SRC_DIV:  vec_wdata = div_q;
      default:           vec_wdata = value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mat_we) begin
      mat[cmd.mat_waddr] <= mat_wdata;
    end
    mat_q <= mat[cmd.mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.vec_we) begin
      vec[cmd.vec_waddr] <= vec_wdata;
    end
    vec_q <= vec[cmd.vec_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rhs_we) begin
      rhs[cmd.rhs_waddr] <= value;
    end
    rhs_q <= rhs[cmd.rhs_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.tmp_ld) begin
      tmp  <= mat_q;
      vtmp <= vec_q;
    end
    if (cmd.m_ld) begin
      m <= div_q;
    end
    if (cmd.best_init || (cmd.best_cmp && st.gt)) begin
      best <= mag_q;
    end
    // floor of the scaled product
    if (cmd.prod_ld) begin
      prod <= lup_pkg::PROD_W'(full >>> lup_pkg::FRAC_BITS);
    end
    unique case (cmd.acc_op)
      lup_pkg::ACC_LOAD_VEC:  acc <= lup_pkg::ACC_W'(vec_q);
      lup_pkg::ACC_LOAD_DIFF: acc <= lup_pkg::ACC_W'(mat_q) - lup_pkg::ACC_W'(prod);
      lup_pkg::ACC_SUB:       acc <= acc - lup_pkg::ACC_W'(prod);
      default:                acc <= acc;
    endcase
    if (cmd.out_ld) begin
      out_index  <= cmd.out_sing ? '0 : cmd.out_index;
      out_sol    <= cmd.out_sing ? '0 : vec_q;
      out_status <= cmd.out_sing;
      out_ovf    <= ovf;
      out_last   <= cmd.out_sing ? 1'b1 : cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.ovf_clr) begin
      ovf <= 1'b0;
    end else if ((cmd.mat_we && cmd.mat_src == lup_pkg::SRC_SAT && acc_ovf) ||
                 (cmd.vec_we && cmd.vec_src == lup_pkg::SRC_SAT && acc_ovf) ||
                 (cmd.mat_we && cmd.mat_src == lup_pkg::SRC_DIV && div_ovf) ||
                 (cmd.vec_we && cmd.vec_src == lup_pkg::SRC_DIV && div_ovf) ||
                 (cmd.div_start && cmd.div_src == lup_pkg::DIV_ACC && acc_ovf)) begin
      ovf <= 1'b1;
    end
  end

endmodule

// File: rtl/lup_ctrl.sv
// lup_ctrl: sequencer for load, factorization, substitution and result transfer
// depends on lup_pkg; drives lup_dp through cmd_t and reads status_t
`timescale 1ns / 1ps

module lup_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [1:0]                           action,
  input  logic [3:0]                           row,
  input  logic [3:0]                           col,
  input  logic                                 cfg_valid,
  input  logic [lup_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lup_pkg::CFG_DAT_W-1:0]        cfg_data,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  lup_pkg::status_t                     st,
  output lup_pkg::cmd_t                        cmd
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_COPY  = 13'b0000000000010,
    S_PSRCH = 13'b0000000000100,
    S_PCHK  = 13'b0000000001000,
    S_SWAP  = 13'b0000000010000,
    S_DIVRD = 13'b0000000100000,
    S_DIVWT = 13'b0000001000000,
    S_UPD   = 13'b0000010000000,
    S_FWD   = 13'b0000100000000,
    S_BWD   = 13'b0001000000000,
    S_BDIV  = 13'b0010000000000,
    S_EMIT  = 13'b0100000000000,
    S_SING  = 13'b1000000000000
  } state_t;

  localparam logic [lup_pkg::IDX_W-1:0] C_LAST = lup_pkg::IDX_W'(lup_pkg::MAX_ORDER - 1);

  state_t                       state;
  logic [2:0]                   ph;
  logic [lup_pkg::IDX_W-1:0]    j;
  logic [lup_pkg::IDX_W-1:0]    i;
  logic [lup_pkg::IDX_W-1:0]    c;
  logic [lup_pkg::IDX_W-1:0]    piv;
  logic [lup_pkg::SIZE_W-1:0]   size_in_use;
  logic [lup_pkg::MINP_W-1:0]   min_pivot;
  logic [lup_pkg::IDX_W-1:0]    n_m1;
  logic                         out_free;
  logic [lup_pkg::IDX_W-1:0]    row_i;
  logic [lup_pkg::IDX_W-1:0]    col_i;
  logic                         in_range;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);
  assign row_i    = lup_pkg::IDX_W'(row);
  assign col_i    = lup_pkg::IDX_W'(col);
  assign in_range = (int'(row) < lup_pkg::MAX_ORDER) && (int'(col) < lup_pkg::MAX_ORDER);

  always_comb begin
    if (size_in_use == '0) begin
      n_m1 = '0;
    end else if (int'(size_in_use) > lup_pkg::N_LIMIT) begin
      n_m1 = lup_pkg::IDX_W'(lup_pkg::N_LIMIT - 1);
    end else begin
      n_m1 = lup_pkg::IDX_W'(size_in_use - 1'b1);
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.min_pivot = min_pivot;
    cmd.out_index = i;
    cmd.out_last  = (i == n_m1);
    unique case (state)
      S_IDLE: begin
        cmd.mat_waddr = {row_i, col_i};
        cmd.rhs_waddr = row_i;
        if (s_tvalid) begin
          cmd.mat_we  = (action == lup_pkg::ACT_WRITE_A) && in_range;
          cmd.rhs_we  = (action == lup_pkg::ACT_WRITE_B) && (int'(row) < lup_pkg::MAX_ORDER);
          cmd.ovf_clr = (action == lup_pkg::ACT_SOLVE);
        end
      end
      S_COPY: begin
        cmd.rhs_raddr = i;
        cmd.vec_waddr = i;
        cmd.vec_src   = lup_pkg::SRC_RHS;
        cmd.vec_we    = (ph != 3'd0);
      end
      S_PSRCH: begin
        cmd.mat_raddr = {i, j};
        cmd.best_init = (ph != 3'd0) && (i == j);
        cmd.best_cmp  = (ph != 3'd0) && (i != j);
      end
      S_PCHK: begin
        cmd.mat_raddr = '0;
      end
      S_SWAP: begin
        cmd.mat_raddr = (ph == 3'd0) ? {j, c} : {piv, c};
        cmd.vec_raddr = (ph == 3'd0) ? j : piv;
        cmd.tmp_ld    = (ph == 3'd1);
        cmd.mat_waddr = (ph == 3'd2) ? {j, c} : {piv, c};
        cmd.vec_waddr = (ph == 3'd2) ? j : piv;
        cmd.mat_src   = (ph == 3'd2) ? lup_pkg::SRC_MEMQ : lup_pkg::SRC_TMP;
        cmd.vec_src   = (ph == 3'd2) ? lup_pkg::SRC_MEMQ : lup_pkg::SRC_TMP;
        cmd.mat_we    = (ph == 3'd2) || (ph == 3'd3);
        cmd.vec_we    = ((ph == 3'd2) || (ph == 3'd3)) && (c == '0);
      end
      S_DIVRD: begin
        cmd.mat_raddr = (ph == 3'd0) ? {j, j} : {i, j};
        cmd.tmp_ld    = (ph == 3'd1);
        cmd.div_start = (ph == 3'd2);
        cmd.div_src   = lup_pkg::DIV_MAT;
      end
      S_DIVWT: begin
        cmd.mat_waddr = {i, j};
        cmd.mat_src   = lup_pkg::SRC_DIV;
        cmd.mat_we    = st.div_done;
        cmd.m_ld      = st.div_done;
      end
      S_UPD: begin
        cmd.mat_raddr = (ph == 3'd0) ? {j, c} : {i, c};
        cmd.mul_sel   = lup_pkg::MUL_M;
        cmd.prod_ld   = (ph == 3'd1);
        cmd.acc_op    = (ph == 3'd2) ? lup_pkg::ACC_LOAD_DIFF : lup_pkg::ACC_HOLD;
        cmd.mat_waddr = {i, c};
        cmd.mat_src   = lup_pkg::SRC_SAT;
        cmd.mat_we    = (ph == 3'd3);
      end
      S_FWD, S_BWD: begin
        cmd.vec_raddr = (ph == 3'd0) ? i : c;
        cmd.mat_raddr = (ph == 3'd5) ? {i, i} : {i, c};
        cmd.mul_sel   = lup_pkg::MUL_V;
        cmd.prod_ld   = (ph == 3'd3);
        unique case (ph)
          3'd1:    cmd.acc_op = lup_pkg::ACC_LOAD_VEC;
          3'd4:    cmd.acc_op = lup_pkg::ACC_SUB;
          default: cmd.acc_op = lup_pkg::ACC_HOLD;
        endcase
        cmd.vec_waddr = i;
        cmd.vec_src   = lup_pkg::SRC_SAT;
        cmd.vec_we    = (state == S_FWD) && (ph == 3'd5);
        cmd.tmp_ld    = (state == S_BWD) && (ph == 3'd6);
        cmd.div_start = (state == S_BWD) && (ph == 3'd7);
        cmd.div_src   = lup_pkg::DIV_ACC;
      end
      S_BDIV: begin
        cmd.vec_waddr = i;
        cmd.vec_src   = lup_pkg::SRC_DIV;
        cmd.vec_we    = st.div_done;
      end
      S_EMIT: begin
        cmd.vec_raddr = i;
        cmd.out_ld    = (ph != 3'd0);
      end
      S_SING: begin
        cmd.out_ld   = out_free;
        cmd.out_sing = 1'b1;
      end
      default: begin
        cmd.mat_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ph          <= '0;
      j           <= '0;
      i           <= '0;
      c           <= '0;
      piv         <= '0;
      m_tvalid    <= 1'b0;
      size_in_use <= lup_pkg::SIZE_W'(16);
      min_pivot   <= lup_pkg::MINP_W'(1);
    end else begin
      if (cfg_valid) begin
        if (cfg_index == lup_pkg::CFG_SIZE) begin
          size_in_use <= cfg_data[lup_pkg::SIZE_W-1:0];
        end else if (cfg_index == lup_pkg::CFG_MIN_PIVOT) begin
          min_pivot <= cfg_data[lup_pkg::MINP_W-1:0];
        end
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.out_ld) begin
        m_tvalid <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid && action == lup_pkg::ACT_SOLVE) begin
            state <= S_COPY;
            i     <= '0;
            ph    <= '0;
          end
        end
        S_COPY: begin
          if (ph == 3'd0) begin
            ph <= 3'd1;
          end else begin
            ph <= 3'd0;
            if (i == n_m1) begin
              state <= S_PSRCH;
              j     <= '0;
              i     <= '0;
            end else begin
              i <= i + 1'b1;
            end
          end
        end
        S_PSRCH: begin
          if (ph == 3'd0) begin
            ph <= 3'd1;
          end else begin
            ph <= 3'd0;
            // on a tie the upper row keeps the pivot
            if (i == j || st.gt) begin
              piv <= i;
            end
            if (i == n_m1) begin
              state <= S_PCHK;
            end else begin
              i <= i + 1'b1;
            end
          end
        end
        S_PCHK: begin
          ph <= 3'd0;
          if (st.low) begin
            state <= S_SING;
          end else if (piv != j) begin
            state <= S_SWAP;
            c     <= '0;
          end else if (j == n_m1) begin
            state <= S_FWD;
            i     <= '0;
          end else begin
            state <= S_DIVRD;
            i     <= j + 1'b1;
          end
        end
        S_SWAP: begin
          ph <= ph + 1'b1;
          if (ph == 3'd3) begin
            ph <= 3'd0;
            if (c == C_LAST) begin
              if (j == n_m1) begin
                state <= S_FWD;
                i     <= '0;
              end else begin
                state <= S_DIVRD;
                i     <= j + 1'b1;
              end
            end else begin
              c <= c + 1'b1;
            end
          end
        end
        S_DIVRD: begin
          if (ph == 3'd2) begin
            state <= S_DIVWT;
            ph    <= 3'd0;
          end else begin
            ph <= ph + 1'b1;
          end
        end
        S_DIVWT: begin
          if (st.div_done) begin
            state <= S_UPD;
            c     <= j + 1'b1;
            ph    <= 3'd0;
          end
        end
        S_UPD: begin
          if (ph == 3'd3) begin
            ph <= 3'd0;
            if (c == n_m1) begin
              if (i == n_m1) begin
                state <= S_PSRCH;
                j     <= j + 1'b1;
                i     <= j + 1'b1;
              end else begin
                state <= S_DIVRD;
                i     <= i + 1'b1;
              end
            end else begin
              c <= c + 1'b1;
            end
          end else begin
            ph <= ph + 1'b1;
          end
        end
        S_FWD: begin
          unique case (ph)
            3'd1: begin
              c  <= '0;
              ph <= (i == '0) ? 3'd5 : 3'd2;
            end
            3'd4: begin
              if (c == i - 1'b1) begin
                ph <= 3'd5;
              end else begin
                c  <= c + 1'b1;
                ph <= 3'd2;
              end
            end
            3'd5: begin
              ph <= 3'd0;
              if (i == n_m1) begin
                state <= S_BWD;
              end else begin
                i <= i + 1'b1;
              end
            end
            default: ph <= ph + 1'b1;
          endcase
        end
        S_BWD: begin
          unique case (ph)
            3'd1: begin
              c  <= i + 1'b1;
              ph <= (i == n_m1) ? 3'd5 : 3'd2;
            end
            3'd4: begin
              if (c == n_m1) begin
                ph <= 3'd5;
              end else begin
                c  <= c + 1'b1;
                ph <= 3'd2;
              end
            end
            3'd7: begin
              state <= S_BDIV;
              ph    <= 3'd0;
            end
            default: ph <= ph + 1'b1;
          endcase
        end
        S_BDIV: begin
          if (st.div_done) begin
            ph <= 3'd0;
            if (i == '0) begin
              state <= S_EMIT;
            end else begin
              i     <= i - 1'b1;
              state <= S_BWD;
            end
          end
        end
        S_EMIT: begin
          if (ph == 3'd0) begin
            if (out_free) begin
              ph <= 3'd1;
            end
          end else begin
            ph <= 3'd0;
            if (i == n_m1) begin
              state <= S_IDLE;
            end else begin
              i <= i + 1'b1;
            end
          end
        end
        S_SING: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_slot_free: assert property (@(posedge clk) disable iff (rst) cmd.out_ld |-> out_free)
    else $error("result loaded over a pending transfer");
  a_pivot_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PCHK |-> (piv >= j) && (piv <= n_m1))
    else $error("pivot row outside the active rows");
  a_swap_needed: assert property (@(posedge clk) disable iff (rst) state == S_SWAP |-> piv != j)
    else $error("row swap with itself");
  a_div_idle: assert property (@(posedge clk) disable iff (rst) cmd.div_start |-> !st.div_busy)
    else $error("division issued while divider busy");
`endif

endmodule

// File: rtl/lup_linear_system_solver.sv
// lup_linear_system_solver: top level of the lup solver, joins controller and datapath
// depends on lup_pkg, lup_ctrl, lup_dp
//
// channel  dir  handshake             payload
// s_*      in   s_tvalid / s_tready   tdata row, col, value; tuser action
// m_*      out  m_tvalid / m_tready   tdata index, solution; tuser status, overflow; tlast
// cfg_*    in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// load items are accepted whenever the controller is idle; a solve runs a
// multiply-accumulate sequence, plus n*(n+1)/2 divisions (set up, 48 quotient bits,
// finish) and a row swap over all 16 columns wherever the pivot moves, one memory port
// read per cycle
// no clearing pass after reset; rst resets controller and config to their defaults and clears the overflow flag
// results wait in the output register; the next result is loaded only when the pending one is taken
`timescale 1ns / 1ps

module lup_linear_system_solver (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [39:0]                          s_tdata,   // row[3:0], col[7:4], value[39:8]
  input  logic [1:0]                           s_tuser,   // action[1:0]
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [39:0]                          m_tdata,   // index[3:0], solution[35:4], zero
  output logic [1:0]                           m_tuser,   // status[0], overflow[1]
  output logic                                 m_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lup_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lup_pkg::CFG_DAT_W-1:0]        cfg_data
);

  lup_pkg::cmd_t                     cmd;
  lup_pkg::status_t                  st;
  logic [lup_pkg::IDX_W-1:0]         out_index;
  logic signed [lup_pkg::DATA_W-1:0] out_sol;
  logic                              out_status;
  logic                              out_ovf;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {4'b0000, out_sol, 4'(out_index)};
  assign m_tuser   = {out_ovf, out_status};

  lup_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .action    (s_tuser),
    .row       (s_tdata[3:0]),
    .col       (s_tdata[7:4]),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .st        (st),
    .cmd       (cmd)
  );

  lup_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .value      (s_tdata[39:8]),
    .st         (st),
    .out_index  (out_index),
    .out_sol    (out_sol),
    .out_status (out_status),
    .out_ovf    (out_ovf),
    .out_last   (m_tlast)
  );

endmodule
